>>> hw/rtl/lvp_pkg.sv
`default_nettype none

package lvp_pkg;

  // Default sizes
  localparam int STACK_DEPTH_DEF = 4096;
  localparam int MAX_LENGTH_DEF  = 65536;

  // Character codes
  localparam logic [7:0] OPEN_BYTE = 8'd40;

  // Field widths of the stream payload
  localparam int SYMBOL_W  = 8;
  localparam int LONGEST_W = 17;
  localparam int OUT_DATA_W = ((LONGEST_W + 7) / 8) * 8;

  // One result transaction
  typedef struct packed {
    logic [LONGEST_W-1:0] longest;
    logic                 string_done;
    logic                 overflow;
  } lvp_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/longest_valid_paren_span_unit.sv
`default_nettype none

// Output: the result of each accepted input transaction is registered in the
// output register.
// Throughput: one character per cycle when out_tready does not stall; the
// stack memory is read every cycle at the entry under the top: pops never stall.
// Reset: synchronous active-low rst_n clears stack count, position, span base,
// best length, overflow flag and output valid; stack contents are not cleared.
module longest_valid_paren_span_unit #(
  parameter int STACK_DEPTH = lvp_pkg::STACK_DEPTH_DEF,
  parameter int MAX_LENGTH  = lvp_pkg::MAX_LENGTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [lvp_pkg::SYMBOL_W-1:0]     in_tdata,   // [7:0] symbol
  input  wire logic                             in_tlast,   // end_of_string
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  output      logic [lvp_pkg::OUT_DATA_W-1:0]   out_tdata,  // [16:0] longest, rest zero
  output      logic                             out_tlast,  // string_done
  output      logic                             out_tuser   // overflow
);

  import lvp_pkg::*;

  logic        accept;
  lvp_result_t res;
  lvp_result_t res_r;
  logic        out_valid_r;

  // Take a transaction whenever the output slot is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  lvp_step #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_LENGTH  (MAX_LENGTH)
  ) u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (accept),
    .item_symbol (in_tdata),
    .item_last   (in_tlast),
    .result      (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(res_r.longest);
  assign out_tlast  = res_r.string_done;
  assign out_tuser  = res_r.overflow;

endmodule

`default_nettype wire

>>> hw/rtl/lvp_stack_ram.sv
`default_nettype none

module lvp_stack_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/lvp_step.sv
`default_nettype none

module lvp_step #(
  parameter int STACK_DEPTH = lvp_pkg::STACK_DEPTH_DEF,
  parameter int MAX_LENGTH  = lvp_pkg::MAX_LENGTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           item_valid,
  input  wire logic [lvp_pkg::SYMBOL_W-1:0]   item_symbol,
  input  wire logic                           item_last,
  output      lvp_pkg::lvp_result_t           result
);

  import lvp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(MAX_LENGTH + 1);
  localparam int DW = $clog2(MAX_LENGTH);

  logic [CW-1:0] count_r, count_nxt, count_upd;
  logic [PW-1:0] pos_r, pos_nxt, pos_upd;
  logic [PW-1:0] base_r, base_nxt, base_upd;
  logic [PW-1:0] best_r, best_nxt, best_upd;
  logic          ovf_r, ovf_nxt, ovf_upd;

  logic          push;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] below_top;
  logic [PW-1:0] span;
  logic          in_range;
  logic          is_open;
  logic          stack_full;

  // Stack storage; the read port always tracks the entry under the top
  lvp_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (DW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (pos_r[DW-1:0]),
    .rd_addr (rd_addr),
    .rd_data (below_top)
  );

  // Next entry under the top for the following cycle; a push writes at
  // count_r and the read aims at count_r - 1, so the two never collide
  assign rd_addr = AW'(count_nxt - CW'(2));

  assign in_range   = pos_r < PW'(MAX_LENGTH);
  assign is_open    = item_symbol == OPEN_BYTE;
  assign stack_full = count_r == CW'(STACK_DEPTH);
  assign push       = item_valid && in_range && is_open && !stack_full;

  // Span closed by a matching closer
  always_comb begin
    if (count_r == CW'(1)) begin
      span = pos_r + PW'(1) - base_r;
    end else begin
      span = pos_r - PW'(below_top);
    end
  end

  // Per-character update
  always_comb begin
    count_upd = count_r;
    pos_upd   = pos_r;
    base_upd  = base_r;
    best_upd  = best_r;
    ovf_upd   = ovf_r;
    if (!in_range) begin
      ovf_upd = 1'b1;
    end else begin
      pos_upd = pos_r + PW'(1);
      if (is_open) begin
        if (stack_full) begin
          ovf_upd = 1'b1;
        end else begin
          count_upd = count_r + CW'(1);
        end
      end else if (count_r == '0) begin
        base_upd = pos_r + PW'(1);
      end else begin
        count_upd = count_r - CW'(1);
        if (span > best_r) begin
          best_upd = span;
        end
      end
    end
  end

  // End of string clears everything after the result is formed
  always_comb begin
    count_nxt = count_r;
    pos_nxt   = pos_r;
    base_nxt  = base_r;
    best_nxt  = best_r;
    ovf_nxt   = ovf_r;
    if (item_valid) begin
      if (item_last) begin
        count_nxt = '0;
        pos_nxt   = '0;
        base_nxt  = '0;
        best_nxt  = '0;
        ovf_nxt   = 1'b0;
      end else begin
        count_nxt = count_upd;
        pos_nxt   = pos_upd;
        base_nxt  = base_upd;
        best_nxt  = best_upd;
        ovf_nxt   = ovf_upd;
      end
    end
  end

  assign result.longest     = LONGEST_W'(best_upd);
  assign result.string_done = item_last;
  assign result.overflow    = ovf_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pos_r   <= '0;
      base_r  <= '0;
      best_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      base_r  <= base_nxt;
      best_r  <= best_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(MAX_LENGTH))
    else $error("position beyond max length");

  a_base_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    base_r <= pos_r)
    else $error("span base ahead of position");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && item_last |=> count_r == '0 && pos_r == '0 && !ovf_r)
    else $error("state not cleared after end of string");
`endif

endmodule

`default_nettype wire

>>> tb/longest_valid_paren_span_unit_test.sv
`timescale 1ns / 100ps

module longest_valid_paren_span_unit_test;

  localparam int STACK_DEPTH = lvp_pkg::STACK_DEPTH_DEF;
  localparam int MAX_LENGTH  = lvp_pkg::MAX_LENGTH_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [7:0] CLOSE_BYTE = 8'd41;

  // One character transaction on the input side
  typedef struct packed {
    logic [7:0] sym;
    logic       eos;
  } char_item_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [lvp_pkg::SYMBOL_W-1:0]   in_tdata   = '0;   // [7:0] symbol
  logic                           in_tlast   = 1'b0; // end_of_string
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [lvp_pkg::OUT_DATA_W-1:0] out_tdata;         // [16:0] longest, rest zero
  logic                           out_tlast;         // string_done
  logic                           out_tuser;         // overflow

  longest_valid_paren_span_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  char_item_t            char_pending_q[$];
  lvp_pkg::lvp_result_t  span_expect_q[$];

  int unsigned tx_idle_pct  = 22;
  int unsigned rx_idle_pct  = 78;
  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  bit          in_fire      = 1'b0;
  bit          out_fire     = 1'b0;

  // Shadow copy of the span tracker
  logic [15:0] open_pos_mem [STACK_DEPTH];
  int unsigned open_count = 0;
  int unsigned char_pos   = 0;
  int unsigned run_base   = 0;
  int unsigned best_span  = 0;
  bit          ovf_sticky = 1'b0;

  function void predict_longest_span(input logic [7:0] sym, input logic eos);
    lvp_pkg::lvp_result_t r;
    int unsigned here;
    int unsigned span;
    here = char_pos;
    if (here >= MAX_LENGTH) begin
      // past the position range: character ignored
      ovf_sticky = 1'b1;
    end else begin
      char_pos = here + 1;
      if (sym == lvp_pkg::OPEN_BYTE) begin
        if (open_count < STACK_DEPTH) begin
          open_pos_mem[open_count] = here[15:0];
          open_count++;
        end else begin
          ovf_sticky = 1'b1;
        end
      end else if (open_count == 0) begin
        // unmatched closer restarts the run
        run_base = here + 1;
      end else begin
        open_count--;
        if (open_count == 0) span = here + 1 - run_base;
        else span = here - 32'(open_pos_mem[open_count-1]);
        if (span > best_span) best_span = span;
      end
    end
    r.longest     = best_span[lvp_pkg::LONGEST_W-1:0];
    r.string_done = eos;
    r.overflow    = ovf_sticky;
    span_expect_q.push_back(r);
    if (eos) begin
      open_count = 0;
      char_pos   = 0;
      run_base   = 0;
      best_span  = 0;
      ovf_sticky = 1'b0;
    end
  endfunction

  // Monitor: check results, predict on accepted characters
  always @(posedge clk) begin : span_monitor
    lvp_pkg::lvp_result_t want;
    in_fire  = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    if (out_fire) begin
      results_seen++;
      if (span_expect_q.size() == 0) begin
        $error("result with nothing expected: longest=%0d", out_tdata[16:0]);
        fail_count++;
      end else begin
        want = span_expect_q.pop_front();
        if (out_tdata[lvp_pkg::LONGEST_W-1:0] !== want.longest) begin
          $error("longest: expected %0d, got %0d", want.longest,
                 out_tdata[lvp_pkg::LONGEST_W-1:0]);
          fail_count++;
        end
        if (out_tdata[lvp_pkg::OUT_DATA_W-1:lvp_pkg::LONGEST_W] !== '0) begin
          $error("tdata pad: expected 0, got %0h",
                 out_tdata[lvp_pkg::OUT_DATA_W-1:lvp_pkg::LONGEST_W]);
          fail_count++;
        end
        if (out_tlast !== want.string_done) begin
          $error("string_done: expected %0b, got %0b", want.string_done, out_tlast);
          fail_count++;
        end
        if (out_tuser !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, out_tuser);
          fail_count++;
        end
      end
    end
    if (in_fire) predict_longest_span(in_tdata, in_tlast);
    if (in_fire || out_fire) stall_cycles = 0;
    else stall_cycles++;
  end

  // Driver: present the next character after each accepted transaction
  always @(negedge clk) begin : char_driver
    char_item_t it;
    if (rst_n && (in_fire || !in_tvalid)) begin
      if (char_pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        it = char_pending_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= it.sym;
        in_tlast  <= it.eos;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random ready, plus one long hold-off to back up the input
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && results_seen >= 200) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog on cycles with no transaction on either side
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [7:0] pick_closer();
    logic [7:0] b;
    b = CLOSE_BYTE;
    if ($urandom_range(7) == 0) begin
      b = 8'($urandom_range(255));
      if (b == lvp_pkg::OPEN_BYTE) b = CLOSE_BYTE;
    end
    return b;
  endfunction

  task automatic push_char(input logic [7:0] sym, input logic eos);
    char_item_t it;
    it.sym = sym;
    it.eos = eos;
    char_pending_q.push_back(it);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  // One random string, mostly balanced with some noise; returns its length
  task automatic push_random_string(output int unsigned len);
    int unsigned depth;
    bit          noisy;
    logic [7:0]  sym;
    len   = ($urandom_range(9) == 0) ? $urandom_range(120, 1) : $urandom_range(24, 1);
    noisy = ($urandom_range(3) == 0);
    depth = 0;
    for (int unsigned i = 0; i < len; i++) begin
      if (noisy) begin
        case ($urandom_range(2))
          0: sym = lvp_pkg::OPEN_BYTE;
          1: sym = CLOSE_BYTE;
          default: sym = 8'($urandom_range(255));
        endcase
      end else if (depth != 0 && (depth >= len - i || $urandom_range(1) == 0)) begin
        sym = pick_closer();
        depth--;
      end else begin
        sym = lvp_pkg::OPEN_BYTE;
        depth++;
      end
      if (!noisy && $urandom_range(19) == 0) sym = 8'($urandom_range(255));
      push_char(sym, i == len - 1);
    end
  endtask

  task automatic push_random_batch(input int unsigned target);
    int unsigned added;
    int unsigned n;
    added = 0;
    while (added < target) begin
      push_random_string(n);
      added += n;
    end
  endtask

  task automatic drain_all();
    while (char_pending_q.size() != 0 || in_tvalid || span_expect_q.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed strings: basic matches, border bytes, unmatched runs
    push_text("()");
    push_text(")()())");
    push_text("(()");
    push_char(8'h00, 1'b1);
    push_char(8'hFF, 1'b0);
    push_char(lvp_pkg::OPEN_BYTE, 1'b0);
    push_char(8'hFF, 1'b1);
    push_text("((");
    push_char(lvp_pkg::OPEN_BYTE, 1'b0);
    push_char(8'd39, 1'b1);
    push_text("()(())");

    // Phase 1: fast sender, slow receiver
    tx_idle_pct = 22;
    rx_idle_pct = 78;
    push_random_batch(480);
    drain_all();

    // Phase 2: roles swapped
    tx_idle_pct = 78;
    rx_idle_pct = 22;
    push_random_batch(480);
    drain_all();

    // Phase 3: no idling
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    push_random_batch(480);
    push_text("()");
    drain_all();

    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
